@@ src/rcrs_pkg.sv @@
// Shared types and constants for the column ray setup core.
// No dependencies; imported by every module under src.
package rcrs_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_COLUMNS_DEF = 4096;
    localparam int DIR_FRAC        = 14;

    localparam logic signed [15:0] DIR_ONE = 16'sd16384;

    localparam logic [12:0] RST_SCREEN_WIDTH = 13'd640;
    localparam logic [15:0] RST_VIEW_DIR_X   = 16'hC000;
    localparam logic [15:0] RST_VIEW_DIR_Y   = 16'h0000;
    localparam logic [15:0] RST_CAM_PLANE_X  = 16'h0000;
    localparam logic [15:0] RST_CAM_PLANE_Y  = 16'd10813;
    localparam logic [23:0] RST_EYE_POS_X    = 24'd98304;
    localparam logic [23:0] RST_EYE_POS_Y    = 24'd98304;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH = 3'd0,
        REG_VIEW_DIR_X   = 3'd1,
        REG_VIEW_DIR_Y   = 3'd2,
        REG_CAM_PLANE_X  = 3'd3,
        REG_CAM_PLANE_Y  = 3'd4,
        REG_EYE_POS_X    = 3'd5,
        REG_EYE_POS_Y    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

@@ src/raycast_column_ray_setup_core.sv @@
// Column ray setup core: camera coordinate, ray direction, map cell, step lengths.
// Depends on rcrs_pkg, rcrs_udiv and rcrs_isqrt.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: column
//  m_      | out | m_tvalid/m_tready  | m_tdata: camera_coord..step_dist_y
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while the output is not backed up; the pipeline depth is set by the
// camera divider, the root unit and the step dividers, one bit per stage each.
// aresetn is synchronous; it clears valid bits and loads the register defaults.
// The whole pipeline moves together; a skid word behind the output register lets
// one more word in after m_tready drops, then s_tready falls until it drains.
module raycast_column_ray_setup_core
    import rcrs_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [11:0] column
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // camera_coord, ray_x, ray_y, cell_x, cell_y,
                                    // step_dist_x, step_dist_y
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    localparam int RW   = 16 + FRAC_BITS;
    localparam int CQW  = 15;
    localparam int CDW  = 13;

    logic [12:0]        width_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [23:0]        eye_x_reg, eye_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RST_SCREEN_WIDTH;
            dir_x_reg   <= RST_VIEW_DIR_X;
            dir_y_reg   <= RST_VIEW_DIR_Y;
            plane_x_reg <= RST_CAM_PLANE_X;
            plane_y_reg <= RST_CAM_PLANE_Y;
            eye_x_reg   <= RST_EYE_POS_X;
            eye_y_reg   <= RST_EYE_POS_Y;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH: width_reg   <= cfg_data[12:0];
                REG_VIEW_DIR_X:   dir_x_reg   <= cfg_data[15:0];
                REG_VIEW_DIR_Y:   dir_y_reg   <= cfg_data[15:0];
                REG_CAM_PLANE_X:  plane_x_reg <= cfg_data[15:0];
                REG_CAM_PLANE_Y:  plane_y_reg <= cfg_data[15:0];
                REG_EYE_POS_X:    eye_x_reg   <= cfg_data;
                REG_EYE_POS_Y:    eye_y_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable and output skid
    logic       skid_valid_reg, skid_valid_next;
    logic       m_valid_reg, m_valid_next;
    logic [127:0] m_data_reg, m_data_next, skid_data_reg, skid_data_next;
    logic       en;
    pipe_ctl_t  ctl_in;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign ctl_in   = '{en: en, valid: s_tvalid};

    // camera divider operands
    logic [CDW-1:0]      w_eff;
    logic signed [14:0]  n_col;
    logic                n_neg, n_big;
    logic [13:0]         n_mag;
    logic [CQW+CDW-1:0]  cam_dividend;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = CDW'(1);
        end else if (32'(width_reg) > 32'(MAX_COLUMNS)) begin
            w_eff = CDW'(MAX_COLUMNS);
        end else begin
            w_eff = width_reg;
        end
        n_col = $signed({2'b00, s_tdata[11:0], 1'b0}) - $signed({2'b00, w_eff});
        n_neg = n_col[14];
        n_big = !n_neg && (n_col >= $signed({2'b00, w_eff}));
        n_mag = n_neg ? 14'(-n_col) : n_col[13:0];
        cam_dividend = {n_mag, 14'b0};
        if (n_neg) begin
            cam_dividend = cam_dividend + (CQW+CDW)'(w_eff) - (CQW+CDW)'(1);
        end
    end

    logic                cdiv_valid;
    logic [0:0][CQW-1:0] cdiv_q;
    logic [1:0]          cdiv_tag;

    rcrs_udiv #(.QW(CQW), .DW(CDW), .TW(2), .NL(1)) u_cam_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl_in),
        .dividend  (cam_dividend),
        .divisor   (w_eff),
        .tag_in    ({n_neg, n_big}),
        .out_valid (cdiv_valid),
        .quotient  (cdiv_q),
        .tag_out   (cdiv_tag)
    );

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // stages B..E
    logic               b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic signed [15:0] b_cam_reg, b_cam_next, c_cam_reg, d_cam_reg, e_cam_reg;
    logic signed [31:0] c_prod_x_reg, c_prod_y_reg;
    logic signed [15:0] d_rx_reg, d_ry_reg, d_rx_next, d_ry_next, e_rx_reg, e_ry_reg;
    logic [31:0]        e_sq_x_reg, e_sq_y_reg;

    always_comb begin
        if (cdiv_tag[0]) begin
            b_cam_next = DIR_ONE;
        end else if (cdiv_tag[1]) begin
            b_cam_next = -$signed(16'(cdiv_q[0]));
        end else begin
            b_cam_next = 16'(cdiv_q[0]);
        end
        d_rx_next = sat16(32'(dir_x_reg) + (c_prod_x_reg >>> DIR_FRAC));
        d_ry_next = sat16(32'(dir_y_reg) + (c_prod_y_reg >>> DIR_FRAC));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= cdiv_valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_cam_reg    <= b_cam_next;
            c_cam_reg    <= b_cam_reg;
            c_prod_x_reg <= plane_x_reg * b_cam_reg;
            c_prod_y_reg <= plane_y_reg * b_cam_reg;
            d_cam_reg    <= c_cam_reg;
            d_rx_reg     <= d_rx_next;
            d_ry_reg     <= d_ry_next;
            e_cam_reg    <= d_cam_reg;
            e_rx_reg     <= d_rx_reg;
            e_ry_reg     <= d_ry_reg;
            e_sq_x_reg   <= 32'(d_rx_reg * d_rx_reg);
            e_sq_y_reg   <= 32'(d_ry_reg * d_ry_reg);
        end
    end

    // |ray|^2 scaled by 2^(2*FRAC_BITS), then root
    logic            sq_valid;
    logic [RW-1:0]   sq_root;
    logic [47:0]     sq_tag;
    pipe_ctl_t       ctl_sq;
    logic [31:0]     len_sq;

    assign len_sq = e_sq_x_reg + e_sq_y_reg;
    assign ctl_sq = '{en: en, valid: e_valid_reg};

    rcrs_isqrt #(.RW(RW), .TW(48)) u_len_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl_sq),
        .radicand  ({len_sq, {(2*FRAC_BITS){1'b0}}}),
        .tag_in    ({e_cam_reg, e_rx_reg, e_ry_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .tag_out   (sq_tag)
    );

    // step length = root / |own component|
    logic signed [15:0]      t_rx, t_ry;
    logic [1:0][RW+15:0]     sd_dividend;
    logic [1:0][15:0]        sd_divisor;
    pipe_ctl_t               ctl_sd;

    assign t_rx = sq_tag[31:16];
    assign t_ry = sq_tag[15:0];
    assign ctl_sd = '{en: en, valid: sq_valid};
    assign sd_dividend[0] = (RW+16)'(sq_root);
    assign sd_dividend[1] = (RW+16)'(sq_root);
    assign sd_divisor[0]  = t_rx[15] ? 16'(-t_rx) : t_rx;
    assign sd_divisor[1]  = t_ry[15] ? 16'(-t_ry) : t_ry;

    logic                sd_valid;
    logic [1:0][RW-1:0]  sd_q;
    logic [47:0]         sd_tag;

    rcrs_udiv #(.QW(RW), .DW(16), .TW(48), .NL(2)) u_step_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl_sd),
        .dividend  (sd_dividend),
        .divisor   (sd_divisor),
        .tag_in    (sq_tag),
        .out_valid (sd_valid),
        .quotient  (sd_q),
        .tag_out   (sd_tag)
    );

    // result word
    logic signed [15:0]  o_cam, o_rx, o_ry;
    logic [RW+31:0]      qx_ext, qy_ext;
    logic [31:0]         step_x, step_y;
    logic [127:0]        pipe_word;

    always_comb begin
        o_cam  = sd_tag[47:32];
        o_rx   = sd_tag[31:16];
        o_ry   = sd_tag[15:0];
        qx_ext = {32'b0, sd_q[0]};
        qy_ext = {32'b0, sd_q[1]};
        if (o_ry == '0) begin
            step_x = '0;
        end else if (o_rx == '0) begin
            step_x = 32'(1) << FRAC_BITS;
        end else begin
            step_x = (|qx_ext[RW+31:32]) ? '1 : qx_ext[31:0];
        end
        if (o_rx == '0) begin
            step_y = '0;
        end else if (o_ry == '0) begin
            step_y = 32'(1) << FRAC_BITS;
        end else begin
            step_y = (|qy_ext[RW+31:32]) ? '1 : qy_ext[31:0];
        end
        pipe_word = {step_y, step_x, eye_y_reg[23:16], eye_x_reg[23:16], o_ry, o_rx, o_cam};
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (en) begin
            if (!m_valid_reg || m_tready) begin
                m_valid_next = sd_valid;
                m_data_next  = pipe_word;
            end else if (sd_valid) begin
                skid_valid_next = 1'b1;
                skid_data_next  = pipe_word;
            end
        end else if (m_tready) begin
            m_valid_next    = 1'b1;
            m_data_next     = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word held with no output word");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready && !skid_valid_reg && sd_valid) |=> !s_tready)
        else $error("input not held off after skid fill");

    a_step_zero_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg[47:32] == 16'd0) == (m_data_reg[95:64] == 32'd0)))
        else $error("step_dist_x zero rule broken");

    a_cam_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($signed(m_data_reg[15:0]) <= DIR_ONE &&
                         $signed(m_data_reg[15:0]) >= -DIR_ONE))
        else $error("camera coordinate out of range");
`endif

endmodule

@@ src/rcrs_udiv.sv @@
// Pipelined restoring divider, one quotient bit per stage, NL lanes in step.
// Depends on rcrs_pkg. Needs dividend < divisor << QW for a valid quotient.
module rcrs_udiv
    import rcrs_pkg::*;
#(
    parameter int QW = 16,
    parameter int DW = 16,
    parameter int TW = 8,
    parameter int NL = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pipe_ctl_t                     ctl,
    input  logic [NL-1:0][QW+DW-1:0]      dividend,
    input  logic [NL-1:0][DW-1:0]         divisor,
    input  logic [TW-1:0]                 tag_in,
    output logic                          out_valid,
    output logic [NL-1:0][QW-1:0]         quotient,
    output logic [TW-1:0]                 tag_out
);

    logic [QW:0]                  valid_reg;
    logic [QW:0][NL-1:0][DW-1:0]  rem_reg, rem_next;
    logic [QW:0][NL-1:0][QW-1:0]  acc_reg, acc_next;
    logic [QW:0][NL-1:0][DW-1:0]  dvs_reg;
    logic [QW:0][TW-1:0]          tag_reg;

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            rem_next[0][l] = dividend[l][QW+DW-1:QW];
            acc_next[0][l] = dividend[l][QW-1:0];
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [NL-1:0][DW:0] trial;
        logic [NL-1:0]       take;
        always_comb begin
            for (int l = 0; l < NL; l++) begin
                trial[l] = {rem_reg[k-1][l], acc_reg[k-1][l][QW-1]};
                take[l]  = trial[l] >= {1'b0, dvs_reg[k-1][l]};
                rem_next[k][l] = take[l] ? DW'(trial[l] - {1'b0, dvs_reg[k-1][l]})
                                         : trial[l][DW-1:0];
                acc_next[k][l] = {acc_reg[k-1][l][QW-2:0], take[l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.en) begin
            valid_reg <= {valid_reg[QW-1:0], ctl.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            dvs_reg <= {dvs_reg[QW-1:0], divisor};
            tag_reg <= {tag_reg[QW-1:0], tag_in};
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient  = acc_reg[QW];
    assign tag_out   = tag_reg[QW];

endmodule

@@ src/rcrs_isqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on rcrs_pkg. Root of a 2*RW bit operand, RW result bits.
module rcrs_isqrt
    import rcrs_pkg::*;
#(
    parameter int RW = 32,
    parameter int TW = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pipe_ctl_t         ctl,
    input  logic [2*RW-1:0]   radicand,
    input  logic [TW-1:0]     tag_in,
    output logic              out_valid,
    output logic [RW-1:0]     root,
    output logic [TW-1:0]     tag_out
);

    logic [RW:0]              valid_reg;
    logic [RW:0][RW+1:0]      rem_reg, rem_next;
    logic [RW:0][RW-1:0]      root_reg, root_next;
    logic [RW:0][2*RW-1:0]    x_reg, x_next;
    logic [RW:0][TW-1:0]      tag_reg;

    assign rem_next[0]  = '0;
    assign root_next[0] = '0;
    assign x_next[0]    = radicand;

    for (genvar k = 1; k <= RW; k++) begin : g_stage
        logic [RW+1:0] shifted;
        logic [RW+1:0] trial;
        logic          take;
        always_comb begin
            shifted = {rem_reg[k-1][RW-1:0], x_reg[k-1][2*RW-1:2*RW-2]};
            trial   = {root_reg[k-1], 2'b01};
            take    = shifted >= trial;
            rem_next[k]  = take ? shifted - trial : shifted;
            root_next[k] = {root_reg[k-1][RW-2:0], take};
            x_next[k]    = {x_reg[k-1][2*RW-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.en) begin
            valid_reg <= {valid_reg[RW-1:0], ctl.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            x_reg    <= x_next;
            tag_reg  <= {tag_reg[RW-1:0], tag_in};
        end
    end

    assign out_valid = valid_reg[RW];
    assign root      = root_reg[RW];
    assign tag_out   = tag_reg[RW];

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for raycast_column_ray_setup_core: random columns under many camera setups.
// Depends on rcrs_pkg and the core RTL; predicts each result word in SystemVerilog.
module testbench
    import rcrs_pkg::*;
();

    localparam int FRAC      = 16;
    localparam int COL_LIMIT = 4096;
    localparam int UNIT      = 16384;
    localparam int SETTLE    = 120;
    localparam int CYCLE_CAP = 600000;
    localparam int N_PROBE   = 9;

    localparam logic [11:0] PROBE_COLS [N_PROBE] = '{12'd0, 12'd1, 12'd319, 12'd320, 12'd638,
                                                     12'd639, 12'd640, 12'd2730, 12'd4095};

    typedef struct packed {
        logic [31:0]        step_dist_y;
        logic [31:0]        step_dist_x;
        logic [7:0]         cell_y;
        logic [7:0]         cell_x;
        logic signed [15:0] ray_y;
        logic signed [15:0] ray_x;
        logic signed [15:0] camera_coord;
    } ray_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;

    // camera setup as the core should hold it
    logic [12:0]        cur_width;
    logic signed [15:0] cur_dir_x, cur_dir_y, cur_plane_x, cur_plane_y;
    logic [23:0]        cur_eye_x, cur_eye_y;

    logic [11:0] column_q[$];
    ray_word_t   ray_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          in_gap = 0;
    int          out_stall = 0;
    bit          in_burst = 0;
    bit          out_burst = 0;

    raycast_column_ray_setup_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint floor_div(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // ray length per grid step along the axis of own
    function automatic logic [31:0] step_length(longint own, longint other);
        longint unsigned d, s, q, r;
        if (other == 0)
            return 32'd0;
        if (own == 0)
            return 32'd1 << FRAC;
        d = own * own;
        s = d + other * other;
        q = s / d;
        r = s % d;
        for (int i = 0; i < 2 * FRAC; i++) begin
            if (q >= (64'd1 << 63))
                return 32'hFFFF_FFFF;
            q = q << 1;
            r = r << 1;
            if (r >= d) begin
                r = r - d;
                q = q + 1;
            end
        end
        q = int_sqrt(q);
        if (q > 64'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return q[31:0];
    endfunction

    function automatic ray_word_t cast_column(logic [11:0] col);
        ray_word_t w;
        longint    wd, cam;
        wd = cur_width;
        if (wd < 1)
            wd = 1;
        if (wd > COL_LIMIT)
            wd = COL_LIMIT;
        cam = floor_div((2 * longint'(col) - wd) * UNIT, wd);
        if (cam > UNIT)
            cam = UNIT;
        if (cam < -UNIT)
            cam = -UNIT;
        w.camera_coord = cam[15:0];
        w.ray_x = clamp16(longint'(cur_dir_x) + floor_div(longint'(cur_plane_x) * cam, UNIT));
        w.ray_y = clamp16(longint'(cur_dir_y) + floor_div(longint'(cur_plane_y) * cam, UNIT));
        w.cell_x = cur_eye_x[23:16];
        w.cell_y = cur_eye_y[23:16];
        w.step_dist_x = step_length(w.ray_x, w.ray_y);
        w.step_dist_y = step_length(w.ray_y, w.ray_x);
        return w;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 5)
            return $urandom_range(15, 60);
        return $urandom_range(0, 3);
    endfunction

    // column driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                ray_q.push_back(cast_column(s_tdata[11:0]));
            if (!(s_tvalid && !s_tready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (column_q.size() > 0) begin
                    s_tdata <= {4'($urandom_range(0, 15)), column_q.pop_front()};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 199) == 0)
                        in_burst = !in_burst;
                    in_gap = in_burst ? 0 : ($urandom_range(0, 2) == 0 ? pick_gap() : 0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        ray_word_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (ray_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", m_tdata);
                end else begin
                    want = ray_q.pop_front();
                    if (got.camera_coord !== want.camera_coord || got.ray_x !== want.ray_x ||
                        got.ray_y !== want.ray_y || got.cell_x !== want.cell_x ||
                        got.cell_y !== want.cell_y || got.step_dist_x !== want.step_dist_x ||
                        got.step_dist_y !== want.step_dist_y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word mismatch: expected %h got %h", want, got);
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 199) == 0)
                    out_burst = !out_burst;
                if (!out_burst && $urandom_range(0, 2) == 0)
                    out_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("raycast_column_ray_setup_core regression: fail");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SCREEN_WIDTH: cur_width   = val[12:0];
            REG_VIEW_DIR_X:   cur_dir_x   = val[15:0];
            REG_VIEW_DIR_Y:   cur_dir_y   = val[15:0];
            REG_CAM_PLANE_X:  cur_plane_x = val[15:0];
            REG_CAM_PLANE_Y:  cur_plane_y = val[15:0];
            REG_EYE_POS_X:    cur_eye_x   = val;
            REG_EYE_POS_Y:    cur_eye_y   = val;
            default: ;
        endcase
    endtask

    // sampled mid-cycle so the driver's updates at the edge have settled
    task automatic drain();
        while (column_q.size() > 0 || s_tvalid || ray_q.size() > 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [23:0] pick_dir();
        case ($urandom_range(0, 5))
            0: return {8'($urandom_range(0, 255)), 16'h8000};
            1: return {8'($urandom_range(0, 255)), 16'h7FFF};
            2: return {8'($urandom_range(0, 255)), 16'h0000};
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        logic [23:0] wv;
        case ($urandom_range(0, 5))
            0: wv = 24'd1;
            1: wv = 24'd4096;
            2: wv = 24'($urandom_range(4097, 8191));
            3: wv = 24'd0;
            default: wv = 24'($urandom_range(1, 1024));
        endcase
        write_reg(REG_SCREEN_WIDTH, {11'($urandom_range(0, 2047)), wv[12:0]});
        write_reg(REG_VIEW_DIR_X, pick_dir());
        write_reg(REG_VIEW_DIR_Y, pick_dir());
        write_reg(REG_CAM_PLANE_X, pick_dir());
        write_reg(REG_CAM_PLANE_Y, pick_dir());
        write_reg(REG_EYE_POS_X, $urandom_range(0, 3) == 0 ? 24'hFFFFFF : 24'($urandom));
        write_reg(REG_EYE_POS_Y, $urandom_range(0, 3) == 0 ? 24'h000000 : 24'($urandom));
    endtask

    initial begin
        int span;
        cur_width = RST_SCREEN_WIDTH;
        cur_dir_x = RST_VIEW_DIR_X;
        cur_dir_y = RST_VIEW_DIR_Y;
        cur_plane_x = RST_CAM_PLANE_X;
        cur_plane_y = RST_CAM_PLANE_Y;
        cur_eye_x = RST_EYE_POS_X;
        cur_eye_y = RST_EYE_POS_Y;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setup: edges, centre, past the width, all ones
        for (int i = 0; i < N_PROBE; i++)
            column_q.push_back(PROBE_COLS[i]);
        drain();

        // zero width, saturating rays, zero components, extreme eye positions
        write_reg(REG_SCREEN_WIDTH, 24'd0);
        write_reg(REG_VIEW_DIR_X, 24'h007FFF);
        write_reg(REG_VIEW_DIR_Y, 24'hFF8000);
        write_reg(REG_CAM_PLANE_X, 24'h007FFF);
        write_reg(REG_CAM_PLANE_Y, 24'h007FFF);
        write_reg(REG_EYE_POS_X, 24'hFFFFFF);
        write_reg(REG_EYE_POS_Y, 24'h000000);
        column_q.push_back(12'd0);
        column_q.push_back(12'd4095);
        drain();
        write_reg(REG_SCREEN_WIDTH, 24'd8191);
        write_reg(REG_VIEW_DIR_X, 24'd0);
        write_reg(REG_VIEW_DIR_Y, 24'd1);
        write_reg(REG_CAM_PLANE_X, 24'd0);
        write_reg(REG_CAM_PLANE_Y, 24'd0);
        column_q.push_back(12'd0);
        column_q.push_back(12'd2048);
        column_q.push_back(12'd4095);
        drain();
        write_reg(REG_VIEW_DIR_X, 24'd1);
        write_reg(REG_VIEW_DIR_Y, 24'd0);
        write_reg(REG_CAM_PLANE_Y, 24'h008000);
        write_reg(REG_SCREEN_WIDTH, 24'd4096);
        column_q.push_back(12'd0);
        column_q.push_back(12'd2048);
        column_q.push_back(12'd4095);
        drain();

        for (int p = 0; p < 12; p++) begin
            random_setup();
            span = (cur_width == 0) ? 1 : (cur_width > COL_LIMIT ? COL_LIMIT : cur_width);
            for (int k = 0; k < 90; k++) begin
                if ($urandom_range(0, 9) == 0)
                    column_q.push_back(12'($urandom_range(0, 4095)));
                else
                    column_q.push_back(12'($urandom_range(0, span - 1)));
            end
            drain();
        end

        if (mismatches == 0 && ray_q.size() == 0) begin
            $display("raycast_column_ray_setup_core regression: pass");
        end else begin
            $display("raycast_column_ray_setup_core regression: fail");
        end
        $finish;
    end
endmodule
